@@ src/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, status codes and the probe record that travels along the
// row of block cells of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int DATA_W       = 32;
  localparam int HEADER_BYTES = 8;
  localparam int GAP_BYTES    = 4;

  localparam logic [DATA_W-1:0] HDR_C  = DATA_W'(HEADER_BYTES);
  localparam logic [DATA_W-1:0] STEP_C = DATA_W'(HEADER_BYTES + GAP_BYTES);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [0:0] REG_BASE  = 1'b0;
  localparam logic [0:0] REG_LIMIT = 1'b1;

  typedef struct packed {
    logic              vld;
    logic              is_free;
    logic [DATA_W-1:0] req_size;
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] addr;      // header address of the block now visited
    logic              hit;
    logic [DATA_W-1:0] hit_size;
    logic [DATA_W-1:0] hit_addr;
  } probe_t;

  typedef struct packed {
    logic              clear;
    logic              append;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] size;
  } cell_ctl_t;

endpackage

@@ src/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a row of block cells; a probe walks the row once
// per request and the controller settles the result when it leaves the row.
// ----------------------------------------------------------------------------
//   Channel  Handshake            Payload
//   in       start & !busy        in_action, in_request_size, in_payload_address
//   out      out_valid (1 cycle)  out_result_address, out_status, out_used_bytes
//   cfg      cfg_we               cfg_index, cfg_wdata
//
// For every request the probe crosses one cell per cycle, and the controller
// registers then settle the append or the counter update.
// The result is on the ports in the first cycle with busy low; a new item may
// be started then.
// Reset is synchronous and empties the heap. The receiver cannot stall.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_payload_address,
  output logic        out_valid,
  output logic [31:0] out_result_address,
  output logic [1:0]  out_status,
  output logic [31:0] out_used_bytes,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int N = ffha_pkg::MAX_BLOCKS;

  ffha_pkg::probe_t    chain [N+1];
  ffha_pkg::cell_ctl_t ctl;

  logic [31:0] base_r, limit_r, end_r, end_nxt, used_r, used_nxt;
  logic [ffha_pkg::CNT_W-1:0] count_r, count_nxt;
  logic        busy_r, busy_nxt, accept;
  logic        ov_r, ov_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic [32:0] need;
  ffha_pkg::probe_t fin;

  assign accept = start && !busy_r;

  always_comb begin
    chain[0]          = '0;
    chain[0].vld      = accept;
    chain[0].is_free  = in_action;
    chain[0].req_size = in_request_size;
    chain[0].payload  = in_payload_address;
    chain[0].addr     = base_r;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    ffha_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (ffha_pkg::IDX_W'(k)),
      .ctl      (ctl),
      .probe_in (chain[k]),
      .probe_out(chain[k+1])
    );
  end

  assign fin  = chain[N];
  assign need = {1'b0, end_r} + {1'b0, fin.req_size} + {1'b0, ffha_pkg::HDR_C};

  always_comb begin
    busy_nxt  = busy_r;
    end_nxt   = end_r;
    used_nxt  = used_r;
    count_nxt = count_r;
    ov_nxt    = 1'b0;
    oaddr_nxt = '0;
    ost_nxt   = ffha_pkg::ST_OK;
    ctl       = '0;
    ctl.idx   = count_r[ffha_pkg::IDX_W-1:0];
    ctl.size  = fin.req_size;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (fin.vld) begin
      busy_nxt = 1'b0;
      ov_nxt   = 1'b1;
      if (fin.is_free == ffha_pkg::ACT_FREE) begin
        if (fin.hit) begin
          used_nxt = used_r - (fin.hit_size + ffha_pkg::HDR_C);
        end else begin
          ost_nxt = ffha_pkg::ST_NOTFOUND;
        end
      end else if (fin.req_size == '0) begin
        ost_nxt = ffha_pkg::ST_ZERO;
      end else if (fin.hit) begin
        oaddr_nxt = fin.hit_addr;
        used_nxt  = used_r + fin.req_size + ffha_pkg::HDR_C;
      end else if (count_r == ffha_pkg::CNT_W'(N) || need >= {1'b0, limit_r}) begin
        ost_nxt = ffha_pkg::ST_OOM;
      end else begin
        // Append a fresh block at the end pointer.
        ctl.append = 1'b1;
        oaddr_nxt  = end_r + ffha_pkg::HDR_C;
        end_nxt    = end_r + fin.req_size + ffha_pkg::STEP_C;
        used_nxt   = used_r + fin.req_size + ffha_pkg::STEP_C;
        count_nxt  = count_r + 1'b1;
      end
    end
    if (cfg_we && cfg_index == ffha_pkg::REG_BASE) begin
      ctl.clear = 1'b1;
      end_nxt   = cfg_wdata;
      used_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      limit_r <= 32'd4063232;
      end_r   <= '0;
      used_r  <= '0;
      count_r <= '0;
      busy_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      end_r   <= end_nxt;
      used_r  <= used_nxt;
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we && cfg_index == ffha_pkg::REG_BASE) begin
        base_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == ffha_pkg::REG_LIMIT) begin
        limit_r <= cfg_wdata;
      end
    end
    oaddr_r <= oaddr_nxt;
    ost_r   <= ost_nxt;
  end

  assign busy               = busy_r;
  assign out_valid          = ov_r;
  assign out_result_address = oaddr_r;
  assign out_status         = ost_r;
  assign out_used_bytes     = used_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ffha_pkg::CNT_W'(N)) else $error("block count beyond table");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy_r)) else $error("result without a request");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffha_pkg::ST_OK |-> out_result_address == '0)
    else $error("failed request granted an address");

endmodule

@@ src/ffha_cell.sv @@
// ----------------------------------------------------------------------------
// ffha_cell
// One block record. Inspects the passing probe, claims or releases its block
// on a match, and hands the probe on to its neighbour through its probe register.
// ----------------------------------------------------------------------------
module ffha_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ffha_pkg::IDX_W-1:0] cell_idx,
  input  ffha_pkg::cell_ctl_t     ctl,
  input  ffha_pkg::probe_t        probe_in,
  output ffha_pkg::probe_t        probe_out
);

  logic [ffha_pkg::DATA_W-1:0] size_r;
  logic                        used_r, used_nxt;
  logic                        live_r, live_nxt;
  ffha_pkg::probe_t            probe_r, probe_nxt;
  logic                        take, rel, mine;

  always_comb begin
    mine = probe_in.vld && !probe_in.hit && live_r;
    take = mine && !probe_in.is_free && !used_r && (probe_in.req_size != '0) &&
           (size_r >= probe_in.req_size);
    rel  = mine && probe_in.is_free &&
           ((probe_in.addr + ffha_pkg::HDR_C) == probe_in.payload);
    probe_nxt = probe_in;
    if (take || rel) begin
      probe_nxt.hit      = 1'b1;
      probe_nxt.hit_size = size_r;
      probe_nxt.hit_addr = probe_in.addr + ffha_pkg::HDR_C;
    end
    if (live_r) begin
      probe_nxt.addr = probe_in.addr + size_r + ffha_pkg::STEP_C;
    end
    used_nxt = used_r;
    live_nxt = live_r;
    if (take) begin
      used_nxt = 1'b1;
    end
    if (rel) begin
      used_nxt = 1'b0;
    end
    if (ctl.append && ctl.idx == cell_idx) begin
      used_nxt = 1'b1;
      live_nxt = 1'b1;
    end
    if (ctl.clear) begin
      used_nxt = 1'b0;
      live_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      live_r      <= 1'b0;
      probe_r.vld <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      live_r      <= live_nxt;
      probe_r.vld <= probe_nxt.vld;
    end
    probe_r.is_free  <= probe_nxt.is_free;
    probe_r.req_size <= probe_nxt.req_size;
    probe_r.payload  <= probe_nxt.payload;
    probe_r.addr     <= probe_nxt.addr;
    probe_r.hit      <= probe_nxt.hit;
    probe_r.hit_size <= probe_nxt.hit_size;
    probe_r.hit_addr <= probe_nxt.hit_addr;
    if (ctl.append && ctl.idx == cell_idx) begin
      size_r <= ctl.size;
    end
  end

  assign probe_out = probe_r;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free requests through the start/busy handshake, keeps
// its own model of the block table and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic        action;
    logic [31:0] size;
    logic [31:0] payload;
  } request_t;

  typedef struct {
    logic [31:0] addr;
    logic [1:0]  status;
    logic [31:0] used;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [31:0] in_request_size;
  logic [31:0] in_payload_address;
  logic        out_valid;
  logic [31:0] out_result_address;
  logic [1:0]  out_status;
  logic [31:0] out_used_bytes;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;

  first_fit_heap_allocator DUT (.*);

  // Model of the heap.
  logic [31:0] m_base, m_limit, m_end, m_used;
  logic [31:0] m_size [ffha_pkg::MAX_BLOCKS];
  logic        m_busy_blk [ffha_pkg::MAX_BLOCKS];
  int          m_count;

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int       errors;
  int       n_sent, n_checked;
  bit       idle_free;   // long stretch with no sender gaps
  bit       hold_sender;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Timeout at %0t", $time);
    $display("Mismatches found");
    $finish;
  end

  function automatic void heap_empty();
    for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++) m_busy_blk[i] = 0;
    m_count = 0;
    m_end   = m_base;
    m_used  = 0;
  endfunction

  function automatic grant_t heap_serve(request_t r);
    grant_t      g;
    logic [31:0] a;
    logic [32:0] need;
    g.addr   = 0;
    g.status = ffha_pkg::ST_OK;
    a        = m_base;
    if (r.action == ffha_pkg::ACT_ALLOC) begin
      if (r.size == 0) begin
        g.status = ffha_pkg::ST_ZERO;
        g.used   = m_used;
        return g;
      end
      for (int i = 0; i < m_count; i++) begin
        if (!m_busy_blk[i] && m_size[i] >= r.size) begin
          m_busy_blk[i] = 1;
          m_used = m_used + r.size + ffha_pkg::HDR_C;
          g.addr = a + ffha_pkg::HDR_C;
          g.used = m_used;
          return g;
        end
        a = a + m_size[i] + ffha_pkg::STEP_C;
      end
      need = {1'b0, m_end} + {1'b0, r.size} + 33'(ffha_pkg::HEADER_BYTES);
      if (m_count >= ffha_pkg::MAX_BLOCKS || need >= {1'b0, m_limit}) begin
        g.status = ffha_pkg::ST_OOM;
      end else begin
        g.addr = m_end + ffha_pkg::HDR_C;
        m_size[m_count] = r.size;
        m_busy_blk[m_count] = 1;
        m_count++;
        m_end  = m_end + r.size + ffha_pkg::STEP_C;
        m_used = m_used + r.size + ffha_pkg::STEP_C;
      end
    end else begin
      g.status = ffha_pkg::ST_NOTFOUND;
      for (int i = 0; i < m_count; i++) begin
        if (a + ffha_pkg::HDR_C == r.payload) begin
          m_used = m_used - (m_size[i] + ffha_pkg::HDR_C);
          m_busy_blk[i] = 0;
          g.status = ffha_pkg::ST_OK;
          break;
        end
        a = a + m_size[i] + ffha_pkg::STEP_C;
      end
    end
    g.used = m_used;
    return g;
  endfunction

  // Payload address of a random existing block, a near miss, or a random value.
  function automatic logic [31:0] pick_payload();
    logic [31:0] a;
    int          k;
    a = m_base;
    if (m_count == 0 || $urandom_range(0, 9) == 0) return $urandom();
    k = $urandom_range(0, m_count - 1);
    for (int i = 0; i < k; i++) a = a + m_size[i] + ffha_pkg::STEP_C;
    a = a + ffha_pkg::HDR_C;
    if ($urandom_range(0, 9) == 0) a = a + 4;
    return a;
  endfunction

  // Sizes stay small mostly so that the table fills and blocks get reused.
  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom();
      2:       return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  task automatic post(logic act, logic [31:0] sz, logic [31:0] pa);
    request_t r;
    r.action  = act;
    r.size    = sz;
    r.payload = pa;
    pending_reqs.push_back(r);
    expected_grants.push_back(heap_serve(r));
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_grants.size() == 0);
    repeat (ffha_pkg::MAX_BLOCKS + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 0;
    if (idx == ffha_pkg::REG_BASE) begin
      m_base = val;
      heap_empty();
    end else begin
      m_limit = val;
    end
  endtask

  // Sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else if (start && !busy) begin
      void'(pending_reqs.pop_front());
      n_sent++;
      if (pending_reqs.size() > 0 && !hold_sender &&
          (idle_free || $urandom_range(0, 99) >= 10)) begin
        in_action          <= pending_reqs[0].action;
        in_request_size    <= pending_reqs[0].size;
        in_payload_address <= pending_reqs[0].payload;
      end else begin
        start <= 0;
      end
    end else if (!start && pending_reqs.size() > 0 && !hold_sender &&
                 (idle_free || $urandom_range(0, 99) >= 10)) begin
      start              <= 1;
      in_action          <= pending_reqs[0].action;
      in_request_size    <= pending_reqs[0].size;
      in_payload_address <= pending_reqs[0].payload;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    grant_t e;
    if (rst_n && out_valid) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: result with none expected: addr %h status %0d used %h", $time,
                 out_result_address, out_status, out_used_bytes);
        errors++;
      end else begin
        e = expected_grants.pop_front();
        n_checked++;
        if (out_result_address !== e.addr) begin
          $display("%0t: result_address expected %h actual %h", $time, e.addr,
                   out_result_address);
          errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_used_bytes !== e.used) begin
          $display("%0t: used_bytes expected %h actual %h", $time, e.used,
                   out_used_bytes);
          errors++;
        end
      end
    end
  end

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) post(ffha_pkg::ACT_FREE, $urandom(), pick_payload());
      else post(ffha_pkg::ACT_ALLOC, pick_size(), $urandom());
      if (i == n / 2) idle_free = ~idle_free;
    end
    drain();
  endtask

  initial begin
    errors = 0; n_sent = 0; n_checked = 0;
    idle_free = 0; hold_sender = 0;
    rst_n = 0; start = 0; in_action = 0; in_request_size = 0;
    in_payload_address = 0; cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    m_base = 0; m_limit = 32'd4063232;
    heap_empty();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: zero size, tiny and huge sizes, reuse, repeated free, misses.
    post(ffha_pkg::ACT_ALLOC, 0, 0);
    post(ffha_pkg::ACT_ALLOC, 1, 0);
    post(ffha_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 0);
    post(ffha_pkg::ACT_ALLOC, 100, 0);
    post(ffha_pkg::ACT_FREE, 0, 32'd8);
    post(ffha_pkg::ACT_FREE, 0, 32'd8);
    post(ffha_pkg::ACT_ALLOC, 1, 0);
    post(ffha_pkg::ACT_ALLOC, 2, 0);
    post(ffha_pkg::ACT_FREE, 0, 32'hFFFF_FFFF);
    post(ffha_pkg::ACT_FREE, 0, 32'd21);
    post(ffha_pkg::ACT_ALLOC, 32'd4063232 - 200, 0);
    drain();
    // Pause the sender until all results are back, then fill the table.
    hold_sender = 1;
    drain();
    hold_sender = 0;
    write_reg(ffha_pkg::REG_LIMIT, 32'hFFFF_FFFF);
    write_reg(ffha_pkg::REG_BASE, 32'hFFFF_FF00);
    for (int i = 0; i < 3; i++) post(ffha_pkg::ACT_ALLOC, 32'd16, 0);
    post(ffha_pkg::ACT_FREE, 0, 32'hFFFF_FF08);
    drain();
    write_reg(ffha_pkg::REG_BASE, 0);
    for (int i = 0; i < ffha_pkg::MAX_BLOCKS + 2; i++) post(ffha_pkg::ACT_ALLOC, 1, 0);
    post(ffha_pkg::ACT_FREE, 0, 32'd8);
    post(ffha_pkg::ACT_ALLOC, 1, 0);
    drain();

    random_phase(400);
    write_reg(ffha_pkg::REG_LIMIT, 0);
    random_phase(100);
    write_reg(ffha_pkg::REG_BASE, $urandom());
    write_reg(ffha_pkg::REG_LIMIT, $urandom());
    random_phase(300);
    write_reg(ffha_pkg::REG_BASE, 32'h1000);
    write_reg(ffha_pkg::REG_LIMIT, 32'h3000);
    random_phase(400);
    write_reg(ffha_pkg::REG_BASE, 0);
    write_reg(ffha_pkg::REG_LIMIT, 32'd4063232);
    random_phase(400);

    $display("Ran %0d requests and checked %0d results over five heap settings,",
             n_sent, n_checked);
    $display("including full-table, wrap-around and zero-limit cases.");
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/ffha_pkg.sv
src/ffha_cell.sv
src/first_fit_heap_allocator.sv
tb/sv/tb_top.sv
